[src/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/prt_pkg.sv]
// package: sizes, codes and types of the pending request table
`timescale 1ns / 1ps

package prt_pkg;

  localparam int NODES     = 64;
  localparam int SLOTS     = 8;
  localparam int TIME_BITS = 32;

  localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SADDR_W = $clog2(NODES * SLOTS);

  // fixed field widths
  localparam int NODE_IN_W = 6;
  localparam int PEER_W    = 6;
  localparam int ADDR_W    = 32;
  localparam int TS_IN_W   = 32;
  localparam int CNT_W     = 4;
  localparam int LIMIT_W   = 16;
  localparam int CMP_W     = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_ENABLE = 2'd1;
  localparam logic [LIMIT_W-1:0]   AGE_LIMIT_RST  = 16'd100;

  // request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic [PEER_W-1:0]    peer;
    logic [ADDR_W-1:0]    addr;
    logic [TIME_BITS-1:0] stamp;
    logic                 ageable;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic [TIME_BITS-1:0] now;
    logic [LIMIT_W-1:0]   limit;
    logic                 age_en;
    logic [PEER_W-1:0]    peer;
    logic [ADDR_W-1:0]    addr;
  } scan_req_t;

  typedef struct packed {
    logic age_hit;
    logic match;
  } scan_res_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROW  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

endpackage

[src/pending_request_table_unit.sv]
// top level of the pending request table: sequencer, slot and row memories
//
//  channel   ports                               handshake
//  input     in_req_type .. in_ageable           start & !busy
//  result    out_done_res .. out_aged_count      out_strobe, one cycle
//  config    cfg_index, cfg_wdata                cfg_we, no wait
//
// insert: the row read issued at accept picks the free slot in the row state, then
// the slot write and the result registers follow in that cycle
// remove: the row state loads the row, then the scan state passes one slot per
// cycle through the compare unit until the first match or the last slot
// the result strobe comes in the cycle after the last busy cycle
// reset clears the per-row init flags, so every bank reads empty at once
// the receiver cannot stall; busy is high from accept until the result shows
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pending_request_table_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_req_type,
  input  logic [prt_pkg::NODE_IN_W-1:0]    in_table_node,
  input  logic [prt_pkg::PEER_W-1:0]       in_peer_node,
  input  logic [prt_pkg::ADDR_W-1:0]       in_req_addr,
  input  logic [prt_pkg::TS_IN_W-1:0]      in_time_stamp,
  input  logic                             in_ageable,
  output logic                             out_strobe,
  output logic                             out_done_res,
  output logic [prt_pkg::CNT_W-1:0]        out_occupancy,
  output logic [prt_pkg::CNT_W-1:0]        out_peak_occupancy,
  output logic [prt_pkg::CNT_W-1:0]        out_aged_count,
  input  logic                             cfg_we,
  input  logic [prt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  prt_pkg::state_t state_r, state_nxt;

  // latched request
  logic                            op_r, op_nxt;
  logic                            node_ok_r, node_ok_nxt;
  logic [prt_pkg::NODE_IN_W-1:0]   node_r, node_nxt;
  logic [prt_pkg::PEER_W-1:0]      peer_r, peer_nxt;
  logic [prt_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic [prt_pkg::TIME_BITS-1:0]   ts_r, ts_nxt;
  logic                            ageable_r, ageable_nxt;

  // scan state
  logic [prt_pkg::SLOTS-1:0]       valid_r, valid_nxt;
  logic [prt_pkg::SLOT_W-1:0]      k_r, k_nxt;
  logic [prt_pkg::CNT_W-1:0]       aged_r, aged_nxt;

  // control and config
  logic [prt_pkg::NODES-1:0]       row_init_r, row_init_nxt;
  logic [prt_pkg::CNT_W-1:0]       peak_r, peak_nxt;
  logic [prt_pkg::LIMIT_W-1:0]     age_limit_r, age_limit_nxt;
  logic                            age_en_r, age_en_nxt;

  // result registers
  logic                            out_strobe_r, out_strobe_nxt;
  logic                            done_r, done_nxt;
  logic [prt_pkg::CNT_W-1:0]       occ_r, occ_nxt;
  logic [prt_pkg::CNT_W-1:0]       aged_out_r, aged_out_nxt;

  // memories
  logic                            vram_we;
  logic [prt_pkg::SLOTS-1:0]       vram_wdata;
  logic [prt_pkg::SLOTS-1:0]       vram_rdata;
  logic                            sram_we;
  logic [prt_pkg::SADDR_W-1:0]     sram_waddr;
  logic [prt_pkg::SADDR_W-1:0]     sram_raddr;
  prt_pkg::slot_t                  sram_wdata;
  prt_pkg::slot_t                  sram_rdata;
  logic [prt_pkg::SLOT_BITS-1:0]   sram_rbits;

  logic [prt_pkg::NODE_W-1:0]      node_idx;
  logic [prt_pkg::SADDR_W-1:0]     base;
  logic [prt_pkg::SLOTS-1:0]       vrow;
  logic                            free_found;
  logic [prt_pkg::SLOT_W-1:0]      free_idx;
  logic [prt_pkg::SLOTS-1:0]       ins_row;
  logic [prt_pkg::CNT_W-1:0]       ins_occ;
  logic                            last;
  logic [prt_pkg::SLOT_W-1:0]      k_rd;
  logic                            cur_valid;
  logic [prt_pkg::SLOTS-1:0]       scan_row;
  prt_pkg::scan_req_t              cmp_req;
  prt_pkg::scan_res_t              cmp_res;

  assign node_idx = prt_pkg::NODE_W'(node_r);
  assign base     = prt_pkg::SADDR_W'(node_idx) * prt_pkg::SADDR_W'(prt_pkg::SLOTS);
  // a row never written since reset reads as empty
  assign vrow     = row_init_r[node_idx] ? vram_rdata : '0;
  assign last     = (k_r == prt_pkg::SLOT_W'(prt_pkg::SLOTS - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = prt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!vrow[i]) begin
        free_found = 1'b1;
        free_idx   = prt_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    ins_row           = vrow;
    ins_row[free_idx] = vrow[free_idx] | free_found;
  end

  assign ins_occ = prt_pkg::CNT_W'($countones(ins_row));

  // read one slot ahead of the one being compared
  always_comb begin
    if (state_r == prt_pkg::S_SCAN) begin
      k_rd = last ? k_r : k_r + prt_pkg::SLOT_W'(1);
    end else begin
      k_rd = '0;
    end
  end

  assign sram_raddr = base + prt_pkg::SADDR_W'(k_rd);
  assign sram_waddr = base + prt_pkg::SADDR_W'(free_idx);
  assign sram_wdata = '{peer: peer_r, addr: addr_r, stamp: ts_r, ageable: ageable_r};
  assign sram_rdata = prt_pkg::slot_t'(sram_rbits);

  assign cur_valid = valid_r[k_r];
  assign cmp_req   = '{now: ts_r, limit: age_limit_r, age_en: age_en_r,
                       peer: peer_r, addr: addr_r};

  always_comb begin
    scan_row      = valid_r;
    scan_row[k_r] = cur_valid & ~cmp_res.age_hit & ~cmp_res.match;
  end

  prt_cmp u_cmp (
    .entry (sram_rdata),
    .valid (cur_valid),
    .req   (cmp_req),
    .res   (cmp_res)
  );

  prt_ram #(
    .WIDTH (prt_pkg::SLOTS),
    .DEPTH (prt_pkg::NODES)
  ) u_row_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (node_idx),
    .wdata (vram_wdata),
    .raddr (prt_pkg::NODE_W'(in_table_node)),
    .rdata (vram_rdata)
  );

  prt_ram #(
    .WIDTH (prt_pkg::SLOT_BITS),
    .DEPTH (prt_pkg::NODES * prt_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .raddr (sram_raddr),
    .rdata (sram_rbits)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    node_ok_nxt    = node_ok_r;
    node_nxt       = node_r;
    peer_nxt       = peer_r;
    addr_nxt       = addr_r;
    ts_nxt         = ts_r;
    ageable_nxt    = ageable_r;
    valid_nxt      = valid_r;
    k_nxt          = k_r;
    aged_nxt       = aged_r;
    row_init_nxt   = row_init_r;
    peak_nxt       = peak_r;
    age_limit_nxt  = age_limit_r;
    age_en_nxt     = age_en_r;
    out_strobe_nxt = 1'b0;
    done_nxt       = done_r;
    occ_nxt        = occ_r;
    aged_out_nxt   = aged_out_r;
    vram_we        = 1'b0;
    vram_wdata     = ins_row;
    sram_we        = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        prt_pkg::CFG_AGE_LIMIT:  age_limit_nxt = cfg_wdata[prt_pkg::LIMIT_W-1:0];
        prt_pkg::CFG_AGE_ENABLE: age_en_nxt    = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      prt_pkg::S_IDLE: begin
        if (start) begin
          op_nxt      = in_req_type;
          node_ok_nxt = (32'(in_table_node) < prt_pkg::NODES);
          node_nxt    = in_table_node;
          peer_nxt    = in_peer_node;
          addr_nxt    = in_req_addr;
          ts_nxt      = prt_pkg::TIME_BITS'(in_time_stamp);
          ageable_nxt = in_ageable;
          state_nxt   = prt_pkg::S_ROW;
        end
      end
      prt_pkg::S_ROW: begin
        if (!node_ok_r) begin
          done_nxt       = 1'b0;
          occ_nxt        = '0;
          aged_out_nxt   = '0;
          out_strobe_nxt = 1'b1;
          state_nxt      = prt_pkg::S_IDLE;
        end else if (op_r == prt_pkg::REQ_INSERT) begin
          sram_we                = free_found;
          vram_we                = free_found;
          vram_wdata             = ins_row;
          row_init_nxt[node_idx] = row_init_r[node_idx] | free_found;
          if (ins_occ > peak_r) begin
            peak_nxt = ins_occ;
          end
          done_nxt       = free_found;
          occ_nxt        = ins_occ;
          aged_out_nxt   = '0;
          out_strobe_nxt = 1'b1;
          state_nxt      = prt_pkg::S_IDLE;
        end else begin
          valid_nxt = vrow;
          k_nxt     = '0;
          aged_nxt  = '0;
          state_nxt = prt_pkg::S_SCAN;
        end
      end
      prt_pkg::S_SCAN: begin
        valid_nxt = scan_row;
        aged_nxt  = aged_r + prt_pkg::CNT_W'(cmp_res.age_hit);
        k_nxt     = k_r + prt_pkg::SLOT_W'(1);
        if (cmp_res.match || last) begin
          vram_we                = 1'b1;
          vram_wdata             = scan_row;
          row_init_nxt[node_idx] = 1'b1;
          done_nxt               = cmp_res.match;
          occ_nxt                = prt_pkg::CNT_W'($countones(scan_row));
          aged_out_nxt           = aged_nxt;
          out_strobe_nxt         = 1'b1;
          state_nxt              = prt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = prt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prt_pkg::S_IDLE;
      out_strobe_r <= 1'b0;
      row_init_r   <= '0;
      peak_r       <= '0;
      age_limit_r  <= prt_pkg::AGE_LIMIT_RST;
      age_en_r     <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      row_init_r   <= row_init_nxt;
      peak_r       <= peak_nxt;
      age_limit_r  <= age_limit_nxt;
      age_en_r     <= age_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    node_ok_r  <= node_ok_nxt;
    node_r     <= node_nxt;
    peer_r     <= peer_nxt;
    addr_r     <= addr_nxt;
    ts_r       <= ts_nxt;
    ageable_r  <= ageable_nxt;
    valid_r    <= valid_nxt;
    k_r        <= k_nxt;
    aged_r     <= aged_nxt;
    done_r     <= done_nxt;
    occ_r      <= occ_nxt;
    aged_out_r <= aged_out_nxt;
  end

  assign busy               = (state_r != prt_pkg::S_IDLE);
  assign out_strobe         = out_strobe_r;
  assign out_done_res       = done_r;
  assign out_occupancy      = occ_r;
  assign out_peak_occupancy = peak_r;
  assign out_aged_count     = aged_out_r;

  // a result only shows once the sequencer is back in idle
  `ASSERT_IMPL(a_strobe_idle, out_strobe_r, state_r == prt_pkg::S_IDLE)
  // an accepted transaction keeps the block busy in the next cycle
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // every transaction passes the row state before its result, so strobes never abut
  `ASSERT_NEXT(a_strobe_gap, out_strobe_r, !out_strobe_r)
  // ageing can free no more entries than a bank holds
  `ASSERT_IMPL(a_aged_bound, out_strobe_r, aged_out_r <= prt_pkg::CNT_W'(prt_pkg::SLOTS))

endmodule

[src/prt_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module prt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/prt_cmp.sv]
// shared slot compare unit: age test and peer/address match for one slot
`timescale 1ns / 1ps

module prt_cmp (
  input  prt_pkg::slot_t     entry,
  input  logic               valid,
  input  prt_pkg::scan_req_t req,
  output prt_pkg::scan_res_t res
);

  logic [prt_pkg::TIME_BITS-1:0] age;
  logic                          old;
  logic                          still_valid;

  // age wraps modulo the timestamp width
  assign age = req.now - entry.stamp;
  assign old = prt_pkg::CMP_W'(age) > prt_pkg::CMP_W'(req.limit);

  assign res.age_hit  = req.age_en & valid & entry.ageable & old;
  assign still_valid  = valid & ~res.age_hit;
  assign res.match    = still_valid & (entry.peer == req.peer) & (entry.addr == req.addr);

endmodule

[tb/sv/pending_request_table_unit_tb.sv]
`timescale 1ns / 1ps
// testbench: directed and random requests checked against a shadow copy of the request table
module pending_request_table_unit_tb;

  typedef struct packed {
    logic                          kind;
    logic [prt_pkg::NODE_IN_W-1:0] node;
    logic [prt_pkg::PEER_W-1:0]    peer;
    logic [prt_pkg::ADDR_W-1:0]    addr;
    logic [prt_pkg::TS_IN_W-1:0]   stamp;
    logic                          ageable;
  } request_t;

  typedef struct packed {
    logic                      done;
    logic [prt_pkg::CNT_W-1:0] occ;
    logic [prt_pkg::CNT_W-1:0] peak;
    logic [prt_pkg::CNT_W-1:0] aged;
  } reply_t;

  // indexes that map to no register
  localparam logic [prt_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [prt_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  request_t cur_req = '0;
  logic out_strobe, out_done_res;
  logic [prt_pkg::CNT_W-1:0] out_occupancy, out_peak_occupancy, out_aged_count;
  logic cfg_we = 1'b0;
  logic [prt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [prt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the table
  logic                          tbl_valid   [prt_pkg::NODES*prt_pkg::SLOTS];
  logic [prt_pkg::PEER_W-1:0]    tbl_peer    [prt_pkg::NODES*prt_pkg::SLOTS];
  logic [prt_pkg::ADDR_W-1:0]    tbl_addr    [prt_pkg::NODES*prt_pkg::SLOTS];
  logic [prt_pkg::TIME_BITS-1:0] tbl_stamp   [prt_pkg::NODES*prt_pkg::SLOTS];
  logic                          tbl_ageable [prt_pkg::NODES*prt_pkg::SLOTS];
  int unsigned                   bank_fill   [prt_pkg::NODES];
  int unsigned                   peak_fill;
  logic [prt_pkg::LIMIT_W-1:0]   age_limit;
  logic                          age_en;

  request_t pending_reqs[$];
  request_t live_reqs[$];
  reply_t   expected_replies[$];

  logic item_taken = 1'b0;
  bit   gap_done = 1'b0;
  int   idle_left = 0;
  int   gap_pct = 0;
  int   idle_cycles = 0;
  logic [prt_pkg::TS_IN_W-1:0] stamp_now;

  int mismatches = 0;
  int n_stored = 0, n_dropped = 0, n_removes = 0, n_matched = 0, n_aged = 0;
  int n_cfg_writes = 0;

  pending_request_table_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (cur_req.kind),
    .in_table_node      (cur_req.node),
    .in_peer_node       (cur_req.peer),
    .in_req_addr        (cur_req.addr),
    .in_time_stamp      (cur_req.stamp),
    .in_ageable         (cur_req.ageable),
    .out_strobe         (out_strobe),
    .out_done_res       (out_done_res),
    .out_occupancy      (out_occupancy),
    .out_peak_occupancy (out_peak_occupancy),
    .out_aged_count     (out_aged_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTED)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one request against the shadow table
  function automatic reply_t apply_request(request_t r);
    reply_t res;
    int base;
    logic [prt_pkg::TIME_BITS-1:0] age;
    res = '0;
    if (r.node < prt_pkg::NODES) begin
      base = r.node * prt_pkg::SLOTS;
      if (r.kind == prt_pkg::REQ_INSERT) begin
        for (int k = 0; k < prt_pkg::SLOTS; k++) begin
          if (!tbl_valid[base+k]) begin
            tbl_valid[base+k] = 1'b1;
            tbl_peer[base+k] = r.peer;
            tbl_addr[base+k] = r.addr;
            tbl_stamp[base+k] = prt_pkg::TIME_BITS'(r.stamp);
            tbl_ageable[base+k] = r.ageable;
            bank_fill[r.node]++;
            if (bank_fill[r.node] > peak_fill) peak_fill = bank_fill[r.node];
            res.done = 1'b1;
            break;
          end
        end
        if (res.done) n_stored++;
        else n_dropped++;
      end else begin
        for (int k = 0; k < prt_pkg::SLOTS; k++) begin
          age = prt_pkg::TIME_BITS'(r.stamp) - tbl_stamp[base+k];
          if (age_en && tbl_valid[base+k] && tbl_ageable[base+k] && age > age_limit) begin
            tbl_valid[base+k] = 1'b0;
            bank_fill[r.node]--;
            res.aged++;
          end
          // the scan stops at the first live match
          if (tbl_valid[base+k] && tbl_peer[base+k] == r.peer && tbl_addr[base+k] == r.addr) begin
            tbl_valid[base+k] = 1'b0;
            bank_fill[r.node]--;
            res.done = 1'b1;
            break;
          end
        end
        n_removes++;
        n_aged += res.aged;
        if (res.done) n_matched++;
      end
      res.occ = prt_pkg::CNT_W'(bank_fill[r.node]);
    end
    res.peak = prt_pkg::CNT_W'(peak_fill);
    return res;
  endfunction

  // transaction accept and register writes
  always @(posedge clk) begin
    item_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) expected_replies.push_back(apply_request(cur_req));
      if (cfg_we) begin
        n_cfg_writes++;
        if (cfg_index == prt_pkg::CFG_AGE_LIMIT) age_limit = cfg_wdata[prt_pkg::LIMIT_W-1:0];
        else if (cfg_index == prt_pkg::CFG_AGE_ENABLE) age_en = cfg_wdata[0];
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!start || item_taken)) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else if (!gap_done && $urandom_range(1, 100) <= gap_pct) begin
        idle_left <= $urandom_range(0, 12);
        gap_done <= 1'b1;
        start <= 1'b0;
      end else begin
        cur_req <= pending_reqs.pop_front();
        gap_done <= 1'b0;
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst_n && out_strobe) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = expected_replies.pop_front();
        if (out_done_res !== want.done) report_mismatch("done_res", out_done_res, want.done);
        if (out_occupancy !== want.occ) report_mismatch("occupancy", out_occupancy, want.occ);
        if (out_peak_occupancy !== want.peak)
          report_mismatch("peak_occupancy", out_peak_occupancy, want.peak);
        if (out_aged_count !== want.aged)
          report_mismatch("aged_count", out_aged_count, want.aged);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_req(logic kind, int node, int peer, logic [prt_pkg::ADDR_W-1:0] addr,
                          logic [prt_pkg::TS_IN_W-1:0] stamp, logic ageable);
    request_t r;
    r.kind = kind;
    r.node = prt_pkg::NODE_IN_W'(node);
    r.peer = prt_pkg::PEER_W'(peer);
    r.addr = addr;
    r.stamp = stamp;
    r.ageable = ageable;
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(logic [prt_pkg::CFG_IDX_W-1:0] idx,
                           logic [prt_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || start || expected_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_directed();
    // fill bank 0 past its last slot, field extremes on the first two entries
    push_req(prt_pkg::REQ_INSERT, 0, 0, 32'h0000_0000, 32'h0000_0000, 1'b1);
    push_req(prt_pkg::REQ_INSERT, 0, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    for (int k = 2; k < prt_pkg::SLOTS; k++)
      push_req(prt_pkg::REQ_INSERT, 0, k, 32'h100 + k, 32'd50, k[0]);
    push_req(prt_pkg::REQ_INSERT, 0, 9, 32'h0000_0999, 32'd60, 1'b1);
    // age exactly at the limit stays, one past it goes
    push_req(prt_pkg::REQ_REMOVE, 0, 63, 32'hFFFF_FFFF, 32'd100, 1'b0);
    push_req(prt_pkg::REQ_REMOVE, 0, 5, 32'h0000_0105, 32'd101, 1'b1);
    push_req(prt_pkg::REQ_REMOVE, 0, 7, 32'h0000_0107, 32'd140, 1'b0);
    push_req(prt_pkg::REQ_REMOVE, 0, 4, 32'h0000_0104, 32'd400, 1'b0);
    // stamp wraps between insert and remove
    push_req(prt_pkg::REQ_INSERT, 63, 1, 32'hDEAD_BEEF, 32'hFFFF_FFF0, 1'b1);
    push_req(prt_pkg::REQ_REMOVE, 63, 2, 32'h0000_0000, 32'h0000_0010, 1'b0);
    push_req(prt_pkg::REQ_REMOVE, 63, 1, 32'hDEAD_BEEF, 32'h0000_0010, 1'b0);
    // remove on an empty bank
    push_req(prt_pkg::REQ_REMOVE, 9, 0, 32'h0000_0000, 32'h0000_0020, 1'b1);
    // duplicate peer and address: only the first goes
    push_req(prt_pkg::REQ_INSERT, 1, 3, 32'h0000_0055, 32'd200, 1'b0);
    push_req(prt_pkg::REQ_INSERT, 1, 3, 32'h0000_0055, 32'd201, 1'b0);
    push_req(prt_pkg::REQ_REMOVE, 1, 3, 32'h0000_0055, 32'd202, 1'b0);
    push_req(prt_pkg::REQ_REMOVE, 1, 3, 32'h0000_0055, 32'd203, 1'b0);
  endtask

  task automatic queue_random(int count, int adv_max);
    request_t r;
    int pick;
    logic [prt_pkg::NODE_IN_W-1:0] focus [4];
    for (int i = 0; i < 4; i++)
      focus[i] = prt_pkg::NODE_IN_W'($urandom_range(0, prt_pkg::NODES - 1));
    for (int i = 0; i < count; i++) begin
      stamp_now += $urandom_range(0, adv_max);
      if ($urandom_range(1, 100) <= 10) begin
        // noise: every field at random
        r.kind = 1'($urandom_range(0, 1));
        r.node = prt_pkg::NODE_IN_W'($urandom);
        r.peer = prt_pkg::PEER_W'($urandom);
        r.addr = $urandom;
        r.stamp = $urandom;
        r.ageable = 1'($urandom_range(0, 1));
      end else begin
        r.node = ($urandom_range(1, 100) <= 80) ? focus[$urandom_range(0, 3)]
                                                : prt_pkg::NODE_IN_W'($urandom);
        r.stamp = stamp_now;
        r.ageable = 1'($urandom_range(0, 1));
        r.peer = prt_pkg::PEER_W'($urandom);
        r.addr = $urandom;
        if (live_reqs.size() == 0 || $urandom_range(1, 100) <= 60) begin
          r.kind = prt_pkg::REQ_INSERT;
          if (live_reqs.size() != 0 && $urandom_range(1, 100) <= 10) begin
            pick = $urandom_range(0, live_reqs.size() - 1);
            r.node = live_reqs[pick].node;
            r.peer = live_reqs[pick].peer;
            r.addr = live_reqs[pick].addr;
          end
          live_reqs.push_back(r);
          if (live_reqs.size() > 64) live_reqs.delete(0);
        end else begin
          r.kind = prt_pkg::REQ_REMOVE;
          if ($urandom_range(1, 100) <= 75) begin
            pick = $urandom_range(0, live_reqs.size() - 1);
            r.node = live_reqs[pick].node;
            r.peer = live_reqs[pick].peer;
            r.addr = live_reqs[pick].addr;
            live_reqs.delete(pick);
          end
        end
      end
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    for (int s = 0; s < prt_pkg::NODES * prt_pkg::SLOTS; s++) begin
      tbl_valid[s] = 1'b0;
      tbl_peer[s] = '0;
      tbl_addr[s] = '0;
      tbl_stamp[s] = '0;
      tbl_ageable[s] = 1'b0;
    end
    for (int n = 0; n < prt_pkg::NODES; n++) bank_fill[n] = 0;
    peak_fill = 0;
    age_limit = prt_pkg::AGE_LIMIT_RST;
    age_en = 1'b1;
    stamp_now = 32'd1000;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of both registers
    gap_pct = 30;
    queue_directed();
    queue_random(110, 40);
    drain();

    // zero limit: anything ageable and older than now goes
    write_reg(CFG_SPARE_A, 16'h1234);
    write_reg(prt_pkg::CFG_AGE_LIMIT, 16'h0000);
    write_reg(prt_pkg::CFG_AGE_ENABLE, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    gap_pct = 0;
    queue_random(110, 3);
    drain();

    // widest limit, stamps running across the wrap
    write_reg(prt_pkg::CFG_AGE_LIMIT, 16'hFFFF);
    stamp_now = 32'hFFFF_0000;
    gap_pct = 30;
    queue_random(110, 20000);
    drain();

    // ageing off
    write_reg(prt_pkg::CFG_AGE_ENABLE, 16'hFFFE);
    write_reg(prt_pkg::CFG_AGE_LIMIT, 16'd40);
    gap_pct = 50;
    queue_random(110, 30);
    drain();

    write_reg(prt_pkg::CFG_AGE_LIMIT, prt_pkg::LIMIT_W'($urandom_range(20, 300)));
    write_reg(prt_pkg::CFG_AGE_ENABLE, 16'h0001);
    gap_pct = 0;
    queue_random(110, int'(age_limit) / 3 + 5);
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d stored inserts, %0d dropped on a full bank, %0d removes",
             n_stored, n_dropped, n_removes);
    $display("%0d removes matched, %0d entries aged out, %0d register writes, %0d mismatches",
             n_matched, n_aged, n_cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/prt_pkg.sv
src/prt_ram.sv
src/prt_cmp.sv
src/pending_request_table_unit.sv
tb/sv/pending_request_table_unit_tb.sv
